FILE: sv/pti_pkg.sv
// Shared types, constants and helper functions of the trajectory interpolator.
`default_nettype none
package pti_pkg;

    // Default table depth.
    localparam int MAX_POINTS_DEF = 256;

    // Shared multiply/divide unit operand widths and step counter width.
    localparam int MD_AW = 66;
    localparam int MD_BW = 33;
    localparam int MD_CW = 7;

    // Configuration register indexes.
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_TIME_OFFSET = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_PERIOD = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    // Request opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Operation of the shared arithmetic unit.
    typedef enum logic {
        MD_MUL = 1'b0,
        MD_DIV = 1'b1
    } t_md_op;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    // One table entry: time plus the five trajectory values.
    typedef struct packed {
        logic [4:0][31:0] v;
        logic [31:0]      t;
    } t_point;

    // Magnitude of a 33-bit two's complement value, read as unsigned.
    function automatic logic [32:0] mag33(input logic [32:0] a);
        return a[32] ? (~a + 33'd1) : a;
    endfunction

    // Saturate a 37-bit signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic [36:0] a);
        logic [31:0] res;
        if (!a[36] && (a[35:31] != 5'd0)) begin
            res = 32'h7FFF_FFFF;
        end else if (a[36] && (a[35:31] != 5'h1F)) begin
            res = 32'h8000_0000;
        end else begin
            res = a[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/pti_table.sv
// Trajectory point memory: one write port, one registered read port.
`default_nettype none
module pti_table
    import pti_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEF,
    parameter int AW    = $clog2(MAX_POINTS_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_point        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_point             o_rdata
);

    t_point r_mem [DEPTH];
    t_point r_rdata;

    // Write one entry when enabled and read one entry every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/pti_muldiv.sv
// Shared bit-serial unit: shift-add multiply and restoring divide.
`default_nettype none
module pti_muldiv
    import pti_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_md_req          i_req,
    input  wire logic [MD_AW-1:0] i_a,
    input  wire logic [MD_BW-1:0] i_b,
    output logic                  o_done,
    output logic [MD_AW-1:0]      o_q,
    output logic [MD_BW-1:0]      o_r
);

    logic             r_busy;
    logic             r_done;
    t_md_op           r_op;
    logic [MD_CW-1:0] r_cnt;
    logic [MD_AW-1:0] r_a;
    logic [MD_BW-1:0] r_b;
    logic [MD_AW-1:0] r_acc;
    logic [MD_BW:0]   r_rem;

    logic [MD_BW:0]   rem_sh;
    logic             rem_ge;

    // One divide step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh = {r_rem[MD_BW-1:0], r_a[MD_AW-1]};
        rem_ge = (rem_sh >= {1'b0, r_b});
    end

    // Sequencing of the steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_rem  <= '0;
                r_cnt  <= (i_req.op == MD_MUL) ? MD_CW'(MD_BW) : MD_CW'(MD_AW);
            end else if (r_busy) begin
                if (r_op == MD_MUL) begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= {r_a[MD_AW-2:0], 1'b0};
                    r_b <= {1'b0, r_b[MD_BW-1:1]};
                end else begin
                    r_rem <= rem_ge ? (rem_sh - {1'b0, r_b}) : rem_sh;
                    r_acc <= {r_acc[MD_AW-2:0], rem_ge};
                    r_a   <= {r_a[MD_AW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - MD_CW'(1);
                if (r_cnt == MD_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_acc;
    assign o_r    = r_rem[MD_BW-1:0];

endmodule
`default_nettype wire

FILE: sv/periodic_trajectory_interpolator_top.sv
// Top level: table writes, periodic wrap, segment scan and five interpolations.
// A write request raises its result strobe in the cycle after it is taken.
// A query wraps its time with a divide, scans the table through the single read port
// and runs five interpolations, each a multiply then a divide on the shared serial unit.
// Short tables and non-positive periods end a query early; results never stall.
// Reset (synchronous, active low) clears the sequencer and both registers; the table is not.
`default_nettype none
module periodic_trajectory_interpolator_top
    import pti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_entry_index,
    input  wire logic [31:0] i_entry_time,
    input  wire logic [31:0] i_entry_x,
    input  wire logic [31:0] i_entry_y,
    input  wire logic [31:0] i_entry_heading,
    input  wire logic [31:0] i_entry_steer,
    input  wire logic [31:0] i_entry_speed,
    input  wire logic [31:0] i_query_time,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [7:0]       o_segment,
    output logic [31:0]      o_ref_x,
    output logic [31:0]      o_ref_y,
    output logic [31:0]      o_ref_heading,
    output logic [31:0]      o_ref_steer,
    output logic [31:0]      o_ref_speed
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_LAST_CHK = 15'b000000000000010,
        S_MOD_ST   = 15'b000000000000100,
        S_MOD_WAIT = 15'b000000000001000,
        S_SCAN_RD  = 15'b000000000010000,
        S_SCAN_CHK = 15'b000000000100000,
        S_P0_RD    = 15'b000000001000000,
        S_P0_LAT   = 15'b000000010000000,
        S_P1_LAT   = 15'b000000100000000,
        S_MUL_ST   = 15'b000001000000000,
        S_MUL_WAIT = 15'b000010000000000,
        S_DIV_WAIT = 15'b000100000000000,
        S_FINISH   = 15'b001000000000000,
        S_ZERO     = 15'b010000000000000,
        S_FAULT    = 15'b100000000000000
    } t_state;

    t_state           r_state;
    logic [8:0]       r_count;
    logic [31:0]      r_offset;
    logic [CW-1:0]    r_n;
    logic [32:0]      r_tq;
    logic [31:0]      r_tmax;
    logic [31:0]      r_r;
    logic [IW-1:0]    r_i;
    logic [31:0]      r_t0;
    logic [31:0]      r_v0 [5];
    logic [31:0]      r_v1 [5];
    logic [32:0]      r_num;
    logic [32:0]      r_den;
    logic [2:0]       r_k;
    logic             r_neg;
    logic             r_done;
    logic [1:0]       r_status;
    logic [7:0]       r_seg;
    logic [31:0]      r_res [5];

    logic [CW-1:0]    n_sat;
    logic [32:0]      tq_sum;
    logic             wr_ok;
    t_point           wdata;
    logic [IW-1:0]    raddr;
    t_point           rdata;
    logic             mem_we;
    t_md_req          md_req;
    logic [MD_AW-1:0] md_a;
    logic [MD_BW-1:0] md_b;
    logic             md_done;
    logic [MD_AW-1:0] md_q;
    logic [MD_BW-1:0] md_r;
    logic [32:0]      dv;
    logic [32:0]      ud;
    logic [34:0]      q_sat;
    logic [35:0]      step_s;
    logic [36:0]      sum37;
    logic [32:0]      p1_den;
    logic [31:0]      wrap_r;

    // Request decode and point-count saturation.
    always_comb begin
        if (32'(r_count) > 32'(MAX_POINTS)) begin
            n_sat = CW'(MAX_POINTS);
        end else begin
            n_sat = CW'(r_count);
        end
        tq_sum = {i_query_time[31], i_query_time} + {r_offset[31], r_offset};
        wr_ok  = (32'(i_entry_index) < 32'(MAX_POINTS));
        mem_we = start && !busy && (i_opcode == OP_WRITE) && wr_ok;
        wdata.t    = i_entry_time;
        wdata.v[0] = i_entry_x;
        wdata.v[1] = i_entry_y;
        wdata.v[2] = i_entry_heading;
        wdata.v[3] = i_entry_steer;
        wdata.v[4] = i_entry_speed;
    end

    // Table read address follows the sequencer state.
    always_comb begin
        unique case (r_state)
            S_IDLE:    raddr = IW'(n_sat - CW'(1));
            S_SCAN_RD: raddr = IW'(r_i + IW'(1));
            S_P0_LAT:  raddr = IW'(r_i + IW'(1));
            default:   raddr = r_i;
        endcase
    end

    pti_table #(
        .DEPTH (MAX_POINTS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (IW'(i_entry_index)),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Operands of the lane being interpolated.
    always_comb begin
        dv     = {r_v1[r_k][31], r_v1[r_k]} - {r_v0[r_k][31], r_v0[r_k]};
        ud     = mag33(r_den);
        p1_den = {rdata.t[31], rdata.t} - {r_t0[31], r_t0};
        if (r_tq[32] && (md_r != '0)) begin
            wrap_r = r_tmax - md_r[31:0];
        end else begin
            wrap_r = md_r[31:0];
        end
        if (md_q > (MD_AW'(1) << 34)) begin
            q_sat = 35'(1) << 34;
        end else begin
            q_sat = md_q[34:0];
        end
        step_s = r_neg ? (~{1'b0, q_sat} + 36'd1) : {1'b0, q_sat};
        sum37  = {{5{r_v0[r_k][31]}}, r_v0[r_k]} + {step_s[35], step_s};
    end

    // Requests to the shared arithmetic unit.
    always_comb begin
        md_req.start = 1'b0;
        md_req.op    = MD_MUL;
        md_a         = '0;
        md_b         = '0;
        unique case (r_state)
            S_MOD_ST: begin
                md_req.start = 1'b1;
                md_req.op    = MD_DIV;
                md_a         = MD_AW'(mag33(r_tq));
                md_b         = MD_BW'(r_tmax);
            end
            S_MUL_ST: begin
                md_req.start = 1'b1;
                md_req.op    = MD_MUL;
                md_a         = MD_AW'(mag33(r_num));
                md_b         = mag33(dv);
            end
            S_MUL_WAIT: begin
                md_req.start = md_done;
                md_req.op    = MD_DIV;
                md_a         = md_q + MD_AW'(ud >> 1);
                md_b         = ud;
            end
            default: begin
                md_req.start = 1'b0;
            end
        endcase
    end

    pti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_done  (md_done),
        .o_q     (md_q),
        .o_r     (md_r)
    );

    // Sequencer, configuration registers and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_count  <= '0;
            r_offset <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POINT_COUNT) begin
                    r_count <= i_cfg_data[8:0];
                end else if (i_cfg_idx == CFG_TIME_OFFSET) begin
                    r_offset <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_seg <= '0;
                        for (int k = 0; k < 5; k++) begin
                            r_res[k] <= '0;
                        end
                        if (i_opcode == OP_WRITE) begin
                            r_status <= ST_OK;
                            r_done   <= 1'b1;
                        end else if (n_sat < CW'(2)) begin
                            r_status <= ST_SHORT;
                            r_done   <= 1'b1;
                        end else begin
                            r_n     <= n_sat;
                            r_tq    <= tq_sum;
                            r_state <= S_LAST_CHK;
                        end
                    end
                end
                S_LAST_CHK: begin
                    r_tmax <= rdata.t;
                    if (rdata.t[31] || (rdata.t == '0)) begin
                        r_status <= ST_PERIOD;
                        r_state  <= S_FAULT;
                    end else begin
                        r_state <= S_MOD_ST;
                    end
                end
                S_MOD_ST: begin
                    r_state <= S_MOD_WAIT;
                end
                S_MOD_WAIT: begin
                    if (md_done) begin
                        r_r     <= wrap_r;
                        r_i     <= '0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (CW'(r_i) < (r_n - CW'(1))) begin
                        r_state <= S_SCAN_CHK;
                    end else begin
                        r_i     <= IW'(r_n - CW'(2));
                        r_state <= S_P0_RD;
                    end
                end
                S_SCAN_CHK: begin
                    if ($signed(rdata.t) <= $signed({1'b0, r_r[30:0]})) begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_state <= S_P0_RD;
                    end
                end
                S_P0_RD: begin
                    r_state <= S_P0_LAT;
                end
                S_P0_LAT: begin
                    r_t0 <= rdata.t;
                    for (int k = 0; k < 5; k++) begin
                        r_v0[k] <= rdata.v[k];
                    end
                    r_state <= S_P1_LAT;
                end
                S_P1_LAT: begin
                    for (int k = 0; k < 5; k++) begin
                        r_v1[k] <= rdata.v[k];
                    end
                    r_num <= {1'b0, r_r} - {r_t0[31], r_t0};
                    r_den <= p1_den;
                    r_k   <= '0;
                    r_seg <= 8'(r_i);
                    if (p1_den == '0) begin
                        r_status <= ST_ZERO;
                        r_state  <= S_ZERO;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_MUL_ST;
                    end
                end
                S_MUL_ST: begin
                    r_neg   <= (r_num[32] ^ dv[32]) ^ r_den[32];
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (md_done) begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (md_done) begin
                        r_res[r_k] <= sat32(sum37);
                        if (r_k == 3'd4) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_MUL_ST;
                        end
                    end
                end
                S_ZERO: begin
                    for (int k = 0; k < 5; k++) begin
                        r_res[k] <= r_v0[k];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FINISH: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FAULT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_segment     = r_seg;
    assign o_ref_x       = r_res[0];
    assign o_ref_y       = r_res[1];
    assign o_ref_heading = r_res[2];
    assign o_ref_steer   = r_res[3];
    assign o_ref_speed   = r_res[4];

    // The arithmetic unit only finishes while the sequencer waits on it.
    a_md_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> (r_state == S_MOD_WAIT || r_state == S_MUL_WAIT ||
                     r_state == S_DIV_WAIT))
        else $error("arithmetic unit finished outside a wait state");

    // The segment scan never runs past the last point.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (CW'(r_i) < (r_n - CW'(1))))
        else $error("segment scan past the last point");

    // A result strobe after a query comes while the sequencer is already idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && $past(r_state) != S_IDLE) |-> (r_state == S_IDLE))
        else $error("result given while a query is still running");

    // The interpolation lane counter stays within the five values.
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_ST) |-> (r_k <= 3'd4))
        else $error("interpolation lane out of range");

endmodule
`default_nettype wire
